@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define CPTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("cpts assertion failed");
// condition must never be true outside reset
`define CPTS_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("cpts forbidden condition seen");
`else
`define CPTS_ASSERT(lbl, clk, rst, prop)
`define CPTS_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ rtl/cpts_pkg.sv @@
`timescale 1ns / 1ps
package cpts_pkg;

   localparam int TASKS   = 8;
   localparam int CNT_W   = 8;
   localparam int TASK_W  = 4;
   localparam int PRIO_W  = 64;
   localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC,
      S_SCAN,
      S_RELOAD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [CNT_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_addr;
   } cnt_ctrl_type;

endpackage

@@ rtl/cpts_req_if.sv @@
`timescale 1ns / 1ps
interface cpts_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink (input valid, input tick, output ready);
endinterface

@@ rtl/cpts_rsp_if.sv @@
`timescale 1ns / 1ps
interface cpts_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] running_task;
   logic [7:0] counter_left;
   logic       switched;
   logic       reloaded;

   modport source (output valid, output running_task, output counter_left,
                   output switched, output reloaded, input ready);
   modport sink (input valid, input running_task, input counter_left,
                 input switched, input reloaded, output ready);
endinterface

@@ rtl/cpts_cnt_file.sv @@
`timescale 1ns / 1ps
module cpts_cnt_file
   import cpts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cnt_ctrl_type     ctrl,
   output logic [CNT_W-1:0] rd_data
);

   logic [CNT_W-1:0] cnt_ff [TASKS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TASKS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else if (ctrl.wr_en) begin
         cnt_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   assign rd_data = cnt_ff[ctrl.rd_addr];

endmodule

@@ rtl/cpts_max_scan.sv @@
`timescale 1ns / 1ps
module cpts_max_scan
   import cpts_pkg::*;
(
   input  logic              clock,
   input  scan_ctrl_type     ctrl,
   input  logic [CNT_W-1:0]  value,
   input  logic [TASK_W-1:0] task_num,
   output logic [TASK_W-1:0] best_task
);

   logic [TASK_W-1:0] best_task_ff;
   logic [CNT_W-1:0]  best_val_ff;
   logic              take;

   // strict greater keeps the lowest index on ties
   assign take      = ctrl.step && (value > best_val_ff);
   assign best_task = take ? task_num : best_task_ff;

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         best_task_ff <= '0;
         best_val_ff  <= '0;
      end else if (take) begin
         best_task_ff <= task_num;
         best_val_ff  <= value;
      end
   end

endmodule

@@ rtl/counter_priority_task_scheduler_core.sv @@
`timescale 1ns / 1ps
// Tick-driven counter-priority scheduler. Each request (tick or no tick) gives
// exactly one response with the running task (0 = idle), its remaining counter and
// switch / reload flags. One compare unit walks the eight task counters one per
// cycle. A request with no tick goes straight to the response; a tick decrements
// the running counter, and a new pick is made when the running task is idle or
// runs out. A pick that finds every counter at zero does a scan, a reload sweep
// through the single counter write port, and a rescan. A new request is taken
// once the previous one has reached the response register; the response may wait
// there while the next request is accepted. Priority writes land in the reload
// register and only affect counters at the next reload.
`include "assert_macros.svh"
module counter_priority_task_scheduler_core
   import cpts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cpts_req_if.sink          req_if,
   cpts_rsp_if.source        rsp_if,
   input  logic              csr_we,
   input  logic [PRIO_W-1:0] csr_wdata
);

   // sequencer state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TASK_W-1:0] running_ff, running_in;
   logic [TASK_W-1:0] prev_ff, prev_in;
   logic              tick_ff, tick_in;
   logic              reload_ff, reload_in;

   // reload priorities
   logic [PRIO_W-1:0] prio_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0] rsp_task_ff, rsp_task_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_sw_ff, rsp_sw_in;
   logic              rsp_rl_ff, rsp_rl_in;

   // shared datapath
   cnt_ctrl_type      cnt_ctrl;
   logic [CNT_W-1:0]  rd_data;
   scan_ctrl_type     scan_ctrl;
   logic [TASK_W-1:0] best_task;
   logic [TASK_W-1:0] scan_task;
   logic [CNT_W-1:0]  dec_val;
   logic [IDX_W-1:0]  run_addr;
   logic              accept;
   logic              last_idx;
   logic              rsp_free;

   cpts_cnt_file u_cnt (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cnt_ctrl),
      .rd_data (rd_data)
   );

   cpts_max_scan u_scan (
      .clock     (clock),
      .ctrl      (scan_ctrl),
      .value     (rd_data),
      .task_num  (scan_task),
      .best_task (best_task)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // task numbers are 1-based, counter slots 0-based
   assign run_addr  = IDX_W'(running_ff - TASK_W'(1));
   assign scan_task = TASK_W'(idx_ff) + TASK_W'(1);
   assign last_idx  = (idx_ff == IDX_W'(TASKS - 1));
   assign dec_val   = (rd_data != '0) ? rd_data - CNT_W'(1) : rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         prio_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            prio_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      tick_ff     <= tick_in;
      reload_ff   <= reload_in;
      rsp_task_ff <= rsp_task_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_rl_ff   <= rsp_rl_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      running_in   = running_ff;
      prev_in      = prev_ff;
      tick_in      = tick_ff;
      reload_in    = reload_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_task_in  = rsp_task_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_rl_in    = rsp_rl_ff;

      cnt_ctrl.wr_en   = 1'b0;
      cnt_ctrl.wr_addr = run_addr;
      cnt_ctrl.wr_data = dec_val;
      cnt_ctrl.rd_addr = run_addr;
      scan_ctrl.clear  = 1'b0;
      scan_ctrl.step   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               prev_in   = running_ff;
               tick_in   = req_if.tick;
               reload_in = 1'b0;
               idx_in    = '0;
               state_in  = req_if.tick ? S_DEC : S_OUT;
            end
         end
         S_DEC: begin
            // decrement the running counter, pick again on idle or expiry
            scan_ctrl.clear = 1'b1;
            idx_in          = '0;
            if (running_ff == '0) begin
               state_in = S_SCAN;
            end else begin
               cnt_ctrl.wr_en = 1'b1;
               state_in       = (dec_val == '0) ? S_SCAN : S_OUT;
            end
         end
         S_SCAN: begin
            cnt_ctrl.rd_addr = idx_ff;
            scan_ctrl.step   = 1'b1;
            idx_in           = idx_ff + IDX_W'(1);
            if (last_idx) begin
               idx_in = '0;
               if (best_task == '0 && !reload_ff) begin
                  state_in = S_RELOAD;
               end else begin
                  running_in = best_task;
                  state_in   = S_OUT;
               end
            end
         end
         S_RELOAD: begin
            // one counter slot per cycle from the priority bytes
            scan_ctrl.clear  = 1'b1;
            cnt_ctrl.wr_en   = 1'b1;
            cnt_ctrl.wr_addr = idx_ff;
            cnt_ctrl.wr_data = prio_ff[idx_ff * CNT_W +: CNT_W];
            idx_in           = idx_ff + IDX_W'(1);
            if (last_idx) begin
               idx_in    = '0;
               reload_in = 1'b1;
               state_in  = S_SCAN;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = running_ff;
               rsp_cnt_in   = (running_ff == '0) ? '0 : rd_data;
               rsp_sw_in    = tick_ff && (running_ff != prev_ff);
               rsp_rl_in    = reload_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.running_task = rsp_task_ff;
   assign rsp_if.counter_left = rsp_cnt_ff;
   assign rsp_if.switched     = rsp_sw_ff;
   assign rsp_if.reloaded     = rsp_rl_ff;

   // running index always names idle or a real task
   `CPTS_NEVER(a_run_range, clock, reset, running_ff > TASK_W'(TASKS))
   // a real running task always reports time left, idle reports none
   `CPTS_ASSERT(a_cnt_idle, clock, reset,
      rsp_valid_ff |-> ((rsp_task_ff == '0) == (rsp_cnt_ff == '0)))
   // an accepted request leaves idle until its response is built
   `CPTS_ASSERT(a_busy, clock, reset, accept |=> state_ff != S_IDLE)
   // a reload is only reported on a tick
   `CPTS_ASSERT(a_rl_tick, clock, reset,
      (state_ff == S_OUT && rsp_free && reload_ff) |-> tick_ff)

endmodule

@@ bench/counter_priority_task_scheduler_core_test.sv @@
`timescale 1ns / 1ps
module counter_priority_task_scheduler_core_test;
   import cpts_pkg::*;

   // 8 ns clock period
   localparam int HALF_PERIOD   = 4;
   // ample for ~1600 requests at their slowest, with long gaps and a hold-off
   localparam int MAX_CYCLES    = 1_000_000;
   // the slowest request runs a scan, a reload sweep and a rescan
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_PRINTED   = 30;
   localparam int TICK_PCT      = 85;

   // one expected response
   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic [CNT_W-1:0]  left;
      logic              switched;
      logic              reloaded;
   } sched_out_type;

   // shapes of priority tables used between phases
   typedef enum {
      PRIO_ZERO,
      PRIO_FULL,
      PRIO_RANDOM,
      PRIO_LOW,
      PRIO_SOLO,
      PRIO_TIED
   } prio_kind_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [PRIO_W-1:0] csr_wdata;

   cpts_req_if req_bus ();
   cpts_rsp_if rsp_bus ();

   counter_priority_task_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the scheduler: counters, running task, reload table
   logic [CNT_W-1:0]  shadow_cnt [1:TASKS];
   logic [TASK_W-1:0] shadow_run;
   logic [PRIO_W-1:0] shadow_prio;

   // responses still owed by the block, oldest first
   sched_out_type pending_outs [$];

   int unsigned mismatches      = 0;
   int unsigned cycle_count     = 0;
   // receiver hold-off, counted down by the receiver process
   int unsigned hold_off_cycles = 0;
   // random idling on the request and response sides
   bit          src_gaps        = 1'b0;
   bit          sink_gaps       = 1'b0;

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // mostly back-to-back, sometimes a short pause, rarely a long one
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // highest counter wins, lowest index on ties, 0 when all counters are empty
   function automatic logic [TASK_W-1:0] largest_counter();
      logic [TASK_W-1:0] best;
      logic [CNT_W-1:0]  best_val;
      best     = '0;
      best_val = '0;
      for (int k = 1; k <= TASKS; k++) begin
         if (shadow_cnt[k] > best_val) begin
            best_val = shadow_cnt[k];
            best     = TASK_W'(k);
         end
      end
      return best;
   endfunction

   // advance the shadow scheduler by one request and return the response it owes
   function automatic sched_out_type schedule_tick(input logic tick_bit);
      sched_out_type     res;
      logic [TASK_W-1:0] prev;
      logic [TASK_W-1:0] next;
      logic              need_pick;
      res       = '0;
      prev      = shadow_run;
      need_pick = 1'b0;
      if (tick_bit) begin
         // idle always asks for a pick; a task does once its slice runs out
         if (prev == '0) begin
            need_pick = 1'b1;
         end else begin
            if (shadow_cnt[prev] > 0) shadow_cnt[prev]--;
            if (shadow_cnt[prev] == 0) need_pick = 1'b1;
         end
         if (need_pick) begin
            next = largest_counter();
            // every counter empty: refill from the table and pick again
            if (next == '0) begin
               for (int k = 1; k <= TASKS; k++)
                  shadow_cnt[k] = shadow_prio[CNT_W*(k-1) +: CNT_W];
               res.reloaded = 1'b1;
               next = largest_counter();
            end
            res.switched = (next != prev);
            shadow_run   = next;
         end
      end
      res.task_id = shadow_run;
      res.left    = (shadow_run == '0) ? '0 : shadow_cnt[shadow_run];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTED)
         $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      sched_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outs.size() == 0) begin
            report_mismatch("response with nothing pending, running_task",
                            rsp_bus.running_task, -1);
         end else begin
            want = pending_outs.pop_front();
            if (rsp_bus.running_task !== want.task_id)
               report_mismatch("running_task", rsp_bus.running_task, want.task_id);
            if (rsp_bus.counter_left !== want.left)
               report_mismatch("counter_left", rsp_bus.counter_left, want.left);
            if (rsp_bus.switched !== want.switched)
               report_mismatch("switched", rsp_bus.switched, want.switched);
            if (rsp_bus.reloaded !== want.reloaded)
               report_mismatch("reloaded", rsp_bus.reloaded, want.reloaded);
         end
      end
   end

   // response ready: long hold-off first, then random gaps, else ready
   initial begin
      int unsigned gap;
      gap           = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_cycles--;
         end else if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (sink_gaps && $urandom_range(0, 3) == 0) gap = gap_len();
         end
      end
   end

   // offer one request from a falling edge, predict it once it is taken
   task automatic send_request(input logic tick_bit);
      int unsigned idle;
      idle = src_gaps ? gap_len() : 0;
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.tick  <= tick_bit;
      do @(posedge clock); while (!req_bus.ready);
      pending_outs.push_back(schedule_tick(tick_bit));
      @(negedge clock);
   endtask

   // stop offering and let every owed response come back
   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      while (pending_outs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // reload table write; only called while the block is idle
   task automatic write_priorities(input logic [PRIO_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      shadow_prio = value;
   endtask

   function automatic logic [PRIO_W-1:0] make_priorities(input prio_kind_type kind);
      logic [PRIO_W-1:0] table_val;
      logic [CNT_W-1:0]  level;
      table_val = '0;
      level     = CNT_W'($urandom_range(1, 255));
      case (kind)
         PRIO_ZERO:   table_val = '0;
         PRIO_FULL:   table_val = '1;
         PRIO_RANDOM: table_val = {$urandom, $urandom};
         PRIO_LOW: begin
            // tiny slices keep reloads frequent
            for (int k = 0; k < TASKS; k++)
               table_val[CNT_W*k +: CNT_W] = CNT_W'($urandom_range(0, 3));
         end
         PRIO_SOLO:
            table_val[CNT_W*$urandom_range(0, TASKS-1) +: CNT_W] = level;
         PRIO_TIED: begin
            // random subset at one level, so ties decide the order
            for (int k = 0; k < TASKS; k++)
               if ($urandom_range(0, 1)) table_val[CNT_W*k +: CNT_W] = level;
         end
         default:     table_val = '0;
      endcase
      return table_val;
   endfunction

   task automatic random_burst(input int count);
      for (int i = 0; i < count; i++)
         send_request($urandom_range(0, 99) < TICK_PCT);
   endtask

   // table at reset is zero: no tick holds idle, every tick reloads into idle
   task automatic test_all_zero_priorities();
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      wait_for_responses();
   endtask

   // a lone task runs out and is picked again after the reload, with no switch
   task automatic test_task_keeps_slot();
      write_priorities(64'h01);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b1);
      wait_for_responses();
      write_priorities(64'h02 << (CNT_W * (TASKS - 1)));
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b1);
      wait_for_responses();
   endtask

   // full table ties everywhere; a new table waits for the next reload
   task automatic test_ties_and_table_change();
      write_priorities('1);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      wait_for_responses();
      write_priorities(64'h0102_0304_0506_0708);
      send_request(1'b1);
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      wait_for_responses();
   endtask

   // phases over every table shape, idling patterns varied, drained in between
   task automatic test_random_phases();
      for (int phase = 0; phase < 14; phase++) begin
         write_priorities(make_priorities(prio_kind_type'(phase % 6)));
         src_gaps  = (phase % 3 != 0);
         sink_gaps = (phase % 4 != 1);
         random_burst(100);
         wait_for_responses();
      end
   endtask

   // receiver stalls for a long stretch while requests keep coming
   task automatic test_receiver_hold_off();
      write_priorities(make_priorities(PRIO_LOW));
      src_gaps        = 1'b0;
      sink_gaps       = 1'b0;
      hold_off_cycles = 400;
      random_burst(40);
      wait_for_responses();
   endtask

   task automatic test_mixed_tail();
      write_priorities(make_priorities(PRIO_RANDOM));
      src_gaps  = 1'b1;
      sink_gaps = 1'b1;
      random_burst(150);
      wait_for_responses();
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.tick  = 1'b0;
      for (int k = 1; k <= TASKS; k++) shadow_cnt[k] = '0;
      shadow_run  = '0;
      shadow_prio = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_all_zero_priorities();
      test_task_keeps_slot();
      test_ties_and_table_change();
      test_random_phases();
      test_receiver_hold_off();
      test_mixed_tail();

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
